### rtl/mwq_pkg.sv
// ----------------------------------------------------------------------------
// Mutex wait queue package
// Shared types, codes and ring helpers for the mutex with a FIFO of waiters.
// ----------------------------------------------------------------------------
package mwq_pkg;

  // Ring size. One slot always stays free, so QUEUE_DEPTH-1 threads can wait.
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  // The user count holds the owner plus up to QUEUE_DEPTH-1 waiters.
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int TID_W   = 16;
  localparam int USERS_W = 5;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [TID_W-1:0] tid_t;

  // Request codes.
  localparam logic [1:0] OP_LOCK    = 2'd0;
  localparam logic [1:0] OP_TRYLOCK = 2'd1;
  localparam logic [1:0] OP_UNLOCK  = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_QUEUED  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_BUSY    = 3'd3;
  localparam logic [2:0] ST_NOUSERS = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    tid_t       thread_id;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               woken_valid;
    tid_t               woken_thread;
    tid_t               owner_now;
    logic [USERS_W-1:0] users_now;
  } rsp_t;

  // Advance a ring pointer, wrapping after the last slot.
  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Number of occupied ring slots between head and tail.
  function automatic cnt_t ring_fill(input ptr_t head, input ptr_t tail);
    logic [PTR_W:0] d;
    if (tail >= head) begin
      d = {1'b0, tail} - {1'b0, head};
    end else begin
      d = {1'b0, tail} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, head};
    end
    return CNT_W'(d);
  endfunction

endpackage

### rtl/mutex_with_fifo_wait_queue_core.sv
// ----------------------------------------------------------------------------
// Mutex with FIFO wait queue
// Lock unit that grants ownership, queues waiters in a ring and hands the
// lock to the oldest waiter on unlock.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------
//  req     | in        | req_valid/req_stall | op, thread_id
//  rsp     | out       | rsp_valid/rsp_stall | status, woken_valid,
//          |           |                     | woken_thread, owner_now, users_now
//
//  Every request gives exactly one response. One item is taken per cycle
//  while rsp is not stalled; an item passes the input register, then the
//  state update and the response register.
//  The rate is set by the single update stage, where owner, count and
//  ring pointers are read and written in the same cycle.
//  Reset (rst, synchronous) frees the mutex and empties the ring; the
//  ring slots themselves are not cleared.
//  A stall on rsp holds the response register and the input register;
//  req_stall rises only while both are full and rsp is stalled.
//
module mutex_with_fifo_wait_queue_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mwq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mwq_pkg::rsp_t rsp
);

  import mwq_pkg::*;

  // Input register stage.
  logic s1_valid;
  req_t s1;

  // Mutex state.
  tid_t owner;
  cnt_t cnt;
  ptr_t head;
  ptr_t tail;
  tid_t wait_slots [QUEUE_DEPTH];

  tid_t owner_next;
  cnt_t cnt_next;
  ptr_t head_next;
  ptr_t tail_next;
  logic slot_wr;
  rsp_t rsp_next;

  // The response register can take a new item when it is empty or draining.
  logic load;
  logic fire;

  assign load      = !rsp_valid || !rsp_stall;
  assign fire      = s1_valid && load;
  // The input register frees up whenever its item moves on.
  assign req_stall = s1_valid && !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1 <= req;
    end
  end

  // The oldest waiter sits at the head slot. A registered copy of that slot
  // is kept ready for the next unlock: it is read at the head pointer that
  // holds after this cycle's update, and a waiter written into an empty ring
  // goes straight into the copy. The ring invariant guarantees that the head
  // slot was written whenever an unlock reads it.
  tid_t head_tid;
  ptr_t head_rd;
  assign head_rd = fire ? head_next : head;

  always_comb begin
    owner_next            = owner;
    cnt_next              = cnt;
    head_next             = head;
    tail_next             = tail;
    slot_wr               = 1'b0;
    rsp_next.status       = ST_OK;
    rsp_next.woken_valid  = 1'b0;
    rsp_next.woken_thread = '0;

    unique case (s1.op)
      OP_LOCK: begin
        if (cnt == '0) begin
          owner_next = s1.thread_id;
          cnt_next   = CNT_W'(1);
        end else if (ring_next(tail) == head) begin
          // A rejected requester is not counted.
          rsp_next.status = ST_FULL;
        end else begin
          slot_wr         = 1'b1;
          tail_next       = ring_next(tail);
          cnt_next        = cnt + CNT_W'(1);
          rsp_next.status = ST_QUEUED;
        end
      end
      OP_TRYLOCK: begin
        if (cnt == '0) begin
          owner_next = s1.thread_id;
          cnt_next   = CNT_W'(1);
        end else begin
          rsp_next.status = ST_BUSY;
        end
      end
      OP_UNLOCK: begin
        // The caller's id is not checked against the owner.
        if (cnt == '0) begin
          rsp_next.status = ST_NOUSERS;
        end else if (cnt == CNT_W'(1)) begin
          owner_next = '0;
          cnt_next   = '0;
        end else begin
          // Hand the lock straight to the oldest waiter.
          owner_next            = head_tid;
          cnt_next              = cnt - CNT_W'(1);
          head_next             = ring_next(head);
          rsp_next.woken_valid  = 1'b1;
          rsp_next.woken_thread = head_tid;
        end
      end
      OP_QUERY: begin
        rsp_next.status = (cnt != '0) ? ST_BUSY : ST_OK;
      end
      default: begin
        rsp_next.status = ST_OK;
      end
    endcase

    rsp_next.owner_now = owner_next;
    // The count may be wider or narrower than the reported field.
    rsp_next.users_now = USERS_W'({{USERS_W{1'b0}}, cnt_next});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner <= '0;
      cnt   <= '0;
      head  <= '0;
      tail  <= '0;
    end else if (fire) begin
      owner <= owner_next;
      cnt   <= cnt_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && slot_wr) begin
      wait_slots[tail] <= s1.thread_id;
    end
    if (fire && slot_wr && tail == head_rd) begin
      head_tid <= s1.thread_id;
    end else begin
      head_tid <= wait_slots[head_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  // The count never exceeds the owner plus a full ring.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("user count above ring capacity");

  // While the mutex is held the ring holds exactly the other users.
  a_ring_fill: assert property (@(posedge clk) disable iff (rst)
    cnt != '0 |-> ring_fill(head, tail) == cnt - CNT_W'(1))
    else $error("ring occupancy does not match user count");

  // A free mutex has an empty ring.
  a_free_empty: assert property (@(posedge clk) disable iff (rst)
    cnt == '0 |-> head == tail)
    else $error("ring not empty while mutex is free");

  // A woken thread is the new owner and the unlock reported success.
  a_woken_owner: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.woken_valid |->
      rsp.owner_now == rsp.woken_thread && rsp.status == ST_OK)
    else $error("woken thread is not the reported owner");

  // State moves only when an item passes the update stage.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(cnt) && $stable(head) && $stable(tail))
    else $error("mutex state changed without an item");

endmodule
